>>> rtl/assert_macros.svh
// Assertion macros shared by the checker module of the flow byte counter.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFBC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfbc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BFBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfbc assertion failed");

`endif

>>> rtl/bfbc_pkg.sv
// Package of the bidirectional flow byte counter: sizes, operation codes,
// the item token that walks along the cell chain, and small helper functions.
package bfbc_pkg;

    localparam int ENTRIES    = 64;
    localparam int OWNERS     = 16;
    localparam int COUNT_BITS = 48;

    localparam int INDEX_W = 6;
    localparam int ENTRY_W = $clog2(ENTRIES);
    localparam int SEL_W   = (ENTRY_W > INDEX_W) ? ENTRY_W : INDEX_W;
    localparam int OWNER_W = (OWNERS > 1) ? $clog2(OWNERS) : 1;
    localparam int HIT_W   = $clog2(OWNERS + 1);
    localparam int SUM_W   = COUNT_BITS + 1;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_PACKET = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef struct packed {
        logic                  active;
        op_t                   op;
        logic [INDEX_W-1:0]    index;
        logic [31:0]           a_ip;
        logic [15:0]           a_port;
        logic [31:0]           b_ip;
        logic [15:0]           b_port;
        logic [3:0]            owner_slot;
        logic [15:0]           length;
        logic [OWNERS-1:0]     taken;
        logic [HIT_W-1:0]      hits;
        logic                  found;
        logic [COUNT_BITS-1:0] count;
        logic [3:0]            rd_owner;
        logic                  rd_valid;
    } token_t;

    function automatic logic [3:0] sat_owner(input logic [3:0] own);
        sat_owner = (32'(own) >= OWNERS) ? 4'(OWNERS - 1) : own;
    endfunction

    function automatic logic [OWNER_W-1:0] owner_idx(input logic [3:0] own);
        owner_idx = OWNER_W'(own);
    endfunction

endpackage

>>> rtl/bidirectional_flow_byte_counter.sv
// Bidirectional flow byte counter, usage notes:
// Items enter on the s_axis channel: tuser carries the operation (load entry,
// packet, read entry, clear table) and tdata carries its operands. Results leave
// on the m_axis channel, one result item for every input item, in order.
// The table is a chain of ENTRIES cells, one entry per cell. An item walks the
// chain one cell per cycle while the chain is not held; each cell loads, counts,
// reads or clears its entry as the item passes, so a later item always sees
// the work of earlier ones. The result of an item is offered once the item has
// passed the token register of every cell. Throughput is one item per cycle
// while results are taken; up to ENTRIES items are in the chain at once.
// When the receiver stalls a waiting result, the whole chain holds and s_axis
// tready drops in the same cycle; it rises again as soon as the result is taken.
// Reset marks every entry invalid and empties the chain. Entry contents and
// counters are not cleared; a read of a never-loaded entry returns undefined data.
// Depends on bfbc_pkg and bfbc_cell.
module bidirectional_flow_byte_counter (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // Fields from bit 0 up: index, a_ip, a_port, b_ip, b_port, owner_slot, length.
    input  logic [127:0] s_axis_tdata,
    // Fields from bit 0 up: op.
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // Fields from bit 0 up: hits, byte_count, entry_owner, entry_valid.
    output logic [63:0]  m_axis_tdata
);
    import bfbc_pkg::*;

    token_t tok_chain [ENTRIES+1];
    token_t tok_head;
    token_t tok_last;
    logic   adv;

    assign tok_last      = tok_chain[ENTRIES];
    assign adv           = !tok_last.active || m_axis_tready;
    assign s_axis_tready = adv;

    always_comb
    begin
        tok_head            = '0;
        tok_head.active     = s_axis_tvalid && adv;
        tok_head.op         = op_t'(s_axis_tuser);
        tok_head.index      = s_axis_tdata[5:0];
        tok_head.a_ip       = s_axis_tdata[37:6];
        tok_head.a_port     = s_axis_tdata[53:38];
        tok_head.b_ip       = s_axis_tdata[85:54];
        tok_head.b_port     = s_axis_tdata[101:86];
        tok_head.owner_slot = s_axis_tdata[105:102];
        tok_head.length     = s_axis_tdata[121:106];
    end

    assign tok_chain[0] = tok_head;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        bfbc_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .cell_id (ENTRY_W'(i)),
            .tok_in  (tok_chain[i]),
            .tok_out (tok_chain[i+1])
        );
    end

    assign m_axis_tvalid = tok_last.active;
    assign m_axis_tdata  = {6'b0, tok_last.rd_valid, tok_last.rd_owner,
                            48'(tok_last.count), 5'(tok_last.hits)};

endmodule

>>> rtl/bfbc_cell.sv
// One cell of the flow table: holds a single connection entry and its counter.
// It updates the entry from the item passing by and hands the item to the next cell.
// Depends on bfbc_pkg.
module bfbc_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic [bfbc_pkg::ENTRY_W-1:0] cell_id,
    input  bfbc_pkg::token_t           tok_in,
    output bfbc_pkg::token_t           tok_out
);
    import bfbc_pkg::*;

    token_t                tok_reg, tok_next;
    logic [31:0]           lip_reg, lip_next;
    logic [15:0]           lport_reg, lport_next;
    logic [31:0]           rip_reg, rip_next;
    logic [15:0]           rport_reg, rport_next;
    logic [3:0]            owner_reg, owner_next;
    logic                  valid_reg, valid_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;

    logic                  sel;
    logic                  fwd;
    logic                  rev;
    logic                  match;
    logic [SUM_W-1:0]      sum;
    logic [COUNT_BITS-1:0] sat;

    assign sel = (SEL_W'(tok_in.index) == SEL_W'(cell_id));
    assign fwd = (lip_reg == tok_in.a_ip) && (lport_reg == tok_in.a_port)
              && (rip_reg == tok_in.b_ip) && (rport_reg == tok_in.b_port);
    assign rev = (rip_reg == tok_in.a_ip) && (rport_reg == tok_in.a_port)
              && (lip_reg == tok_in.b_ip) && (lport_reg == tok_in.b_port);
    assign match = valid_reg && (fwd || rev) && !tok_in.taken[owner_idx(owner_reg)];
    assign sum = {1'b0, cnt_reg} + SUM_W'(tok_in.length);
    assign sat = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];

    always_comb
    begin
        tok_next   = tok_in;
        lip_next   = lip_reg;
        lport_next = lport_reg;
        rip_next   = rip_reg;
        rport_next = rport_reg;
        owner_next = owner_reg;
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        if (tok_in.active)
        begin
            case (tok_in.op)
                OP_LOAD:
                begin
                    if (sel)
                    begin
                        lip_next   = tok_in.a_ip;
                        lport_next = tok_in.a_port;
                        rip_next   = tok_in.b_ip;
                        rport_next = tok_in.b_port;
                        owner_next = sat_owner(tok_in.owner_slot);
                        valid_next = 1'b1;
                        cnt_next   = '0;
                    end
                end
                OP_PACKET:
                begin
                    if (match)
                    begin
                        cnt_next = sat;
                        tok_next.taken[owner_idx(owner_reg)] = 1'b1;
                        tok_next.hits = tok_in.hits + HIT_W'(1);
                        if (!tok_in.found)
                        begin
                            tok_next.found = 1'b1;
                            tok_next.count = sat;
                        end
                    end
                end
                OP_READ:
                begin
                    if (sel)
                    begin
                        tok_next.count    = cnt_reg;
                        tok_next.rd_owner = owner_reg;
                        tok_next.rd_valid = valid_reg;
                    end
                end
                OP_CLEAR:
                begin
                    valid_next = 1'b0;
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            tok_reg   <= tok_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lip_reg   <= lip_next;
            lport_reg <= lport_next;
            rip_reg   <= rip_next;
            rport_reg <= rport_next;
            owner_reg <= owner_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> rtl/bfbc_checker.sv
// Port-level checker for the bidirectional flow byte counter, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module bfbc_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [63:0]  m_axis_tdata
);

    logic out_stall;
    logic out_free;
    logic pkt_hit;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_free  = !m_axis_tvalid || m_axis_tready;
    assign pkt_hit   = m_axis_tvalid && (m_axis_tdata[4:0] != 5'd0);

    `BFBC_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
    `BFBC_ASSERT_SAME(a_in_stall, out_stall, !s_axis_tready)
    `BFBC_ASSERT_SAME(a_in_free, out_free, s_axis_tready)
    `BFBC_ASSERT_SAME(a_pkt_fields, pkt_hit, m_axis_tdata[63:53] == 11'd0)

endmodule

bind bidirectional_flow_byte_counter bfbc_checker u_bfbc_checker (.*);
